/* src/f2pcm_pkg.sv */
// shared types and format codes for the float to pcm converter
package f2pcm_pkg;

  typedef enum logic [2:0] {
    FMT_U8  = 3'd0,
    FMT_S16 = 3'd1,
    FMT_S24 = 3'd2,
    FMT_S32 = 3'd3,
    FMT_F32 = 3'd4
  } fmt_t;

  localparam logic [2:0] FMT_RESET = 3'd1;

  typedef struct packed {
    logic [31:0] float_sample;
    logic        end_of_block;
  } in_word_t;

  typedef struct packed {
    logic [31:0] pcm_word;
    logic [2:0]  valid_bytes;
    logic        end_of_block_out;
  } out_word_t;

  // decoded sample after clamp, before scaling
  typedef struct packed {
    logic        is_nan;
    logic        neg;
    logic [23:0] mant;
    logic [7:0]  rsh;    // right shift of mant*k, i.e. -e
  } dec_t;

endpackage

/* src/f2pcm_decode.sv */
// unpacks the float sample and clamps its magnitude to one
module f2pcm_decode
  import f2pcm_pkg::*;
(
  input  logic [31:0] float_sample,
  output dec_t        dec
);

  logic [7:0]  expf;
  logic [22:0] frac;

  assign expf = float_sample[30:23];
  assign frac = float_sample[22:0];

  always_comb begin
    dec.is_nan = (expf == 8'hff) && (frac != 23'd0);
    dec.neg    = float_sample[31];
    if (expf >= 8'd127) begin
      dec.mant = 24'h800000;
      dec.rsh  = 8'd23;
    end else if (expf == 8'd0) begin
      dec.mant = {1'b0, frac};
      dec.rsh  = 8'd149;
    end else begin
      dec.mant = {1'b1, frac};
      dec.rsh  = 8'd150 - expf;
    end
  end

endmodule

/* src/f2pcm_scale.sv */
// scales the clamped sample, rounds twice to nearest even, packs the pcm word
module f2pcm_scale
  import f2pcm_pkg::*;
(
  input  dec_t        dec,
  input  logic [2:0]  fmt,
  output logic [31:0] pcm_word,
  output logic [2:0]  valid_bytes,
  input  logic [31:0] raw_bits
);

  logic [38:0] prod;      // mant * k, k at most 32767 (2^31 handled by shift)
  logic [5:0]  len;
  logic [4:0]  s1;
  logic [23:0] p24;
  logic [8:0]  ex;        // signed exponent after float rounding
  logic [32:0] mag;
  logic [32:0] sval;
  logic [31:0] sat32;
  logic [9:0]  u8v;
  logic        pow2;
  logic [38:0] rem1, half1;
  logic [24:0] q1;
  logic [63:0] wide, rem2, half2;
  logic [32:0] q2;
  logic [7:0]  rs;

  always_comb begin
    pow2 = (fmt == FMT_S24) || (fmt == FMT_S32);
    unique case (fmt)
      FMT_U8:  prod = 39'(dec.mant) * 39'd127;
      FMT_S16: prod = 39'(dec.mant) * 39'd32767;
      default: prod = 39'(dec.mant);
    endcase
    len = 6'd0;
    for (int i = 0; i < 39; i++) begin
      if (prod[i]) len = 6'(i + 1);
    end
    // first rounding to a 24-bit float significand
    s1    = (len > 6'd24) ? 5'(len - 6'd24) : 5'd0;
    rem1  = prod & ((39'd1 << s1) - 39'd1);
    half1 = (s1 == 5'd0) ? 39'd0 : (39'd1 << (s1 - 5'd1));
    q1    = 25'(prod >> s1);
    if (s1 != 5'd0 && (rem1 > half1 || (rem1 == half1 && q1[0]))) q1 = q1 + 25'd1;
    // exponent, with 2^31 folded in for the 32-bit formats
    ex = 9'(s1) - 9'(dec.rsh) + (pow2 ? 9'd31 : 9'd0);
    p24   = 24'd0;
    rs    = 8'd0;
    wide  = 64'd0;
    rem2  = 64'd0;
    half2 = 64'd0;
    q2    = 33'd0;
    if (!ex[8]) begin
      mag = (ex > 9'd8) ? 33'h1_0000_0000 : 33'(q1) << ex[3:0];
    end else begin
      rs    = 8'(-ex);
      wide  = {q1, 39'd0};
      mag   = 33'd0;
      if (rs <= 8'd39) begin
        q2    = 33'(wide >> (7'd39 + 7'(rs)));
        rem2  = (wide >> 39) & ((64'd1 << rs) - 64'd1);
        half2 = (rs == 8'd0) ? 64'd0 : (64'd1 << (rs - 8'd1));
        if (rs != 8'd0 && (rem2 > half2 || (rem2 == half2 && q2[0]))) q2 = q2 + 33'd1;
        mag = q2;
      end
    end
    if (dec.is_nan) mag = 33'd0;
    sat32 = (!dec.neg && mag > 33'h7fff_ffff) ? 32'h7fff_ffff : 32'(mag);
    sval  = dec.neg ? 33'd0 - mag : mag;
    if (dec.neg) sat32 = 32'(sval);
    u8v = dec.neg ? 10'd128 - 10'(mag) : 10'd128 + 10'(mag);
    pcm_word    = 32'd0;
    valid_bytes = 3'd4;
    unique case (fmt)
      FMT_U8: begin
        pcm_word    = (u8v > 10'd255) ? 32'd255 : 32'(u8v);
        valid_bytes = 3'd1;
      end
      FMT_S16: begin
        pcm_word    = {16'd0, sval[15:0]};
        valid_bytes = 3'd2;
      end
      FMT_S24: begin
        pcm_word    = {8'd0, sat32[31:8]};
        valid_bytes = 3'd3;
      end
      FMT_S32: pcm_word = sat32;
      FMT_F32: pcm_word = raw_bits;
      default: pcm_word = 32'd0;
    endcase
  end

endmodule

/* src/float_to_pcm_sample_converter_top.sv */
// top level of the float to pcm sample converter
//
//  port group  dir  payload     handshake
//  in_*        in   in_word_t   in_valid / in_stall
//  out_*       out  out_word_t  out_valid / out_stall
//  cfg_*       in   3-bit fmt   cfg_we
//
// one word per cycle unless the result stalls; a word passes the input register, then the result register
// the conversion is one pass of logic between the two registers
// rst_n clears the valid flags and sets the format to signed 16
// a stalled result holds; the pipe keeps taking words while any stage is free
module float_to_pcm_sample_converter_top
  import f2pcm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data,
  input  logic      cfg_we,
  input  logic [2:0] cfg_wdata
);

  logic [2:0] fmt_r;
  in_word_t   in_r;
  logic       in_v_r;
  out_word_t  out_r;
  logic       out_v_r;
  dec_t       dec;
  logic [31:0] pcm;
  logic [2:0]  nb;
  logic        adv_out;

  // result register can load when empty or being taken
  assign adv_out  = !out_v_r || !out_stall;
  // input register can load when empty or moving on
  assign in_stall = in_v_r && !adv_out;

  always_ff @(posedge clk) begin
    if (!rst_n) fmt_r <= FMT_RESET;
    else if (cfg_we) fmt_r <= cfg_wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (!in_stall) in_v_r <= in_valid;
      if (adv_out)   out_v_r <= in_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) in_r <= in_data;
    if (adv_out && in_v_r) out_r <= '{pcm, nb, in_r.end_of_block};
  end

  f2pcm_decode u_dec (
    .float_sample(in_r.float_sample),
    .dec         (dec)
  );

  f2pcm_scale u_scale (
    .dec        (dec),
    .fmt        (fmt_r),
    .pcm_word   (pcm),
    .valid_bytes(nb),
    .raw_bits   (in_r.float_sample)
  );

  assign out_valid = out_v_r;
  assign out_data  = out_r;

  // a stalled result stays valid
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_stall |=> out_v_r) else $error("result dropped");
  // input only stalls when the result stage is stuck
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_v_r && out_stall) else $error("spurious stall");
  // byte count always meaningful
  a_nb: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> out_r.valid_bytes != 3'd0) else $error("bad byte count");

endmodule

/* test/tb_float_to_pcm_sample_converter_top.sv */
// testbench for the float to pcm sample converter: random and corner samples in every format
`timescale 1ns / 1ps

module tb_float_to_pcm_sample_converter_top;
  import f2pcm_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int PHASES      = 13;
  localparam int RAND_ITEMS  = 115;

  // format walk: reset value first, then every code including the unused ones
  localparam logic [2:0] FMT_UNUSED_5 = 3'd5;
  localparam logic [2:0] FMT_UNUSED_6 = 3'd6;
  localparam logic [2:0] FMT_UNUSED_7 = 3'd7;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_data;
  logic      cfg_we = 1'b0;
  logic [2:0] cfg_wdata = '0;

  in_word_t  sample_queue[$];     // words waiting for the driver
  out_word_t pcm_expected[$];     // predicted results, oldest first
  logic [2:0] fmt_shadow = FMT_RESET;
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;
  int        mismatches = 0;
  int        cycle_count = 0;

  float_to_pcm_sample_converter_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // predictor: exact integer model of clamp, float32 product and rint
  // ---------------------------------------------------------------------------

  // round to nearest even after dropping the low sh bits
  function automatic logic [63:0] rne_drop(logic [63:0] v, int sh);
    logic [63:0] q, rem, half;
    if (sh == 0) return v;
    if (sh > 63) return 64'd0;
    q    = v >> sh;
    rem  = v & ((64'd1 << sh) - 64'd1);
    half = 64'd1 << (sh - 1);
    if (rem > half || (rem == half && q[0])) q = q + 64'd1;
    return q;
  endfunction

  // signed rint(f32(clamp(x) * k)) as 64-bit two's complement; nan gives zero
  function automatic logic [63:0] scaled_int(logic [31:0] bits, logic [63:0] k);
    logic [7:0]  ex_f;
    logic [22:0] frac;
    logic [63:0] m, p, mag;
    int          e, len;
    ex_f = bits[30:23];
    frac = bits[22:0];
    if (ex_f == 8'hFF && frac != 0) return 64'd0;
    if (ex_f >= 8'd127) begin
      // magnitude one or more, infinity included: clamp to one
      m = 64'h80_0000;
      e = -23;
    end else if (ex_f == 8'd0) begin
      m = {41'd0, frac};
      e = -149;
    end else begin
      m = {40'd0, 1'b1, frac};
      e = int'(ex_f) - 150;
    end
    p = m * k;
    len = 0;
    for (int i = 0; i < 64; i++) if (p[i]) len = i + 1;
    // product rounded to a 24-bit float mantissa
    if (len > 24) begin
      p = rne_drop(p, len - 24);
      e = e + len - 24;
    end
    if (e >= 0) mag = (e > 32) ? (64'd1 << 40) : (p << e);
    else mag = (-e > 63) ? 64'd0 : rne_drop(p, -e);
    return bits[31] ? (64'd0 - mag) : mag;
  endfunction

  function automatic out_word_t predict_pcm(in_word_t w, logic [2:0] fmt);
    out_word_t   r;
    logic [63:0] v;
    logic signed [63:0] sv;
    logic [31:0] s32;
    r.end_of_block_out = w.end_of_block;
    r.pcm_word = '0;
    r.valid_bytes = 3'd4;
    case (fmt)
      FMT_U8: begin
        sv = $signed(scaled_int(w.float_sample, 64'd127)) + 64'sd128;
        if (sv < 0) sv = 0;
        if (sv > 255) sv = 255;
        r.pcm_word = {24'd0, sv[7:0]};
        r.valid_bytes = 3'd1;
      end
      FMT_S16: begin
        v = scaled_int(w.float_sample, 64'd32767);
        r.pcm_word = {16'd0, v[15:0]};
        r.valid_bytes = 3'd2;
      end
      FMT_S24, FMT_S32: begin
        v = scaled_int(w.float_sample, 64'h8000_0000);
        // plus one overflows 2^31, saturate
        if (!v[63] && v > 64'h7FFF_FFFF) v = 64'h7FFF_FFFF;
        s32 = v[31:0];
        if (fmt == FMT_S24) begin
          s32 = $signed(s32) >>> 8;
          r.pcm_word = {8'd0, s32[23:0]};
          r.valid_bytes = 3'd3;
        end else begin
          r.pcm_word = s32;
        end
      end
      FMT_F32: r.pcm_word = w.float_sample;
      default: ;  // unused codes give zero with four bytes
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // driver: feeds words from the queue, idles and stalls at random
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid  <= 1'b0;
      out_stall <= 1'b0;
    end else begin
      // hold a stalled word, else load the next one or idle
      if (!in_valid || !in_stall) begin
        if (sample_queue.size() > 0 && $urandom_range(99, 0) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data  <= sample_queue.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= ($urandom_range(99, 0) < recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: predicts on accepted input, checks accepted results
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string msg);
    mismatches++;
    $display("mismatch at %0t: %s", $time, msg);
  endtask

  always @(posedge clk) begin
    out_word_t exp_w;
    if (rst_n) begin
      if (in_valid && !in_stall) pcm_expected.push_back(predict_pcm(in_data, fmt_shadow));
      if (out_valid && !out_stall) begin
        if (pcm_expected.size() == 0) begin
          report_mismatch($sformatf("unexpected result %h", out_data));
        end else begin
          exp_w = pcm_expected.pop_front();
          if (out_data.pcm_word !== exp_w.pcm_word)
            report_mismatch($sformatf("pcm_word %h, want %h (fmt %0d)",
                                      out_data.pcm_word, exp_w.pcm_word, fmt_shadow));
          if (out_data.valid_bytes !== exp_w.valid_bytes)
            report_mismatch($sformatf("valid_bytes %0d, want %0d",
                                      out_data.valid_bytes, exp_w.valid_bytes));
          if (out_data.end_of_block_out !== exp_w.end_of_block_out)
            report_mismatch($sformatf("end_of_block_out %b, want %b",
                                      out_data.end_of_block_out, exp_w.end_of_block_out));
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_float_to_pcm_sample_converter_top: done, errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  function automatic in_word_t make_word(logic [31:0] bits);
    in_word_t w;
    w.float_sample = bits;
    w.end_of_block = 1'($urandom_range(1, 0));
    return w;
  endfunction

  function automatic logic [31:0] random_sample();
    int pick;
    pick = $urandom_range(99, 0);
    if (pick < 55)       // nominal audio range
      return {1'($urandom_range(1, 0)), 8'($urandom_range(127, 100)), 23'($urandom)};
    else if (pick < 70)  // tiny and subnormal values
      return {1'($urandom_range(1, 0)), 8'($urandom_range(99, 0)), 23'($urandom)};
    else if (pick < 80)  // just below one in magnitude, where rounding to the top matters
      return {1'($urandom_range(1, 0)), 8'd126, 23'h7FFF00 | 23'($urandom_range(255, 0))};
    else                 // any bit pattern: out of range, infinity, nan
      return $urandom;
  endfunction

  task automatic push_corners();
    logic [31:0] corners[$];
    corners = '{32'h0000_0000, 32'h8000_0000, 32'h3F80_0000, 32'hBF80_0000,
                32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000, 32'hFFFF_FFFF,
                32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'h0000_0001, 32'h807F_FFFF,
                32'h3F00_0000, 32'hBF00_0000, 32'h3F7F_FFFF, 32'hBF7F_FFFF,
                32'h4000_0000, 32'h3C01_0204, 32'h3800_0100, 32'h3B80_0000};
    foreach (corners[i]) sample_queue.push_back(make_word(corners[i]));
  endtask

  task automatic drain();
    while (sample_queue.size() > 0 || in_valid || pcm_expected.size() > 0) @(posedge clk);
    // margin before touching the format register
    repeat (4) @(posedge clk);
  endtask

  initial begin
    logic [2:0] fmt_walk[PHASES];
    fmt_walk = '{FMT_S16, FMT_U8, FMT_S24, FMT_S32, FMT_F32, FMT_UNUSED_5, FMT_U8,
                 FMT_S16, FMT_S24, FMT_S32, FMT_F32, FMT_UNUSED_6, FMT_UNUSED_7};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int ph = 0; ph < PHASES; ph++) begin
      // idle mix: sender light / receiver heavy, then swapped, then none
      case (ph * 3 / PHASES)
        0:       begin send_idle_pct = 15; recv_idle_pct = 51; end
        1:       begin send_idle_pct = 51; recv_idle_pct = 15; end
        default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      endcase
      // the first phase runs on the reset format
      if (ph > 0) begin
        cfg_we    <= 1'b1;
        cfg_wdata <= fmt_walk[ph];
        @(posedge clk);
        cfg_we      <= 1'b0;
        fmt_shadow  = fmt_walk[ph];
        @(posedge clk);
      end
      if (ph < 6) push_corners();
      for (int i = 0; i < RAND_ITEMS; i++) sample_queue.push_back(make_word(random_sample()));
      drain();
    end
    if (mismatches == 0) begin
      $display("tb_float_to_pcm_sample_converter_top: done, clean");
    end else begin
      $display("tb_float_to_pcm_sample_converter_top: done, errors");
    end
    $finish;
  end

endmodule

/* files.f */
src/f2pcm_pkg.sv
src/f2pcm_decode.sv
src/f2pcm_scale.sv
src/float_to_pcm_sample_converter_top.sv
test/tb_float_to_pcm_sample_converter_top.sv
